[rtl/cbx_pkg.sv]
// ----------------------------------------------------------------------------
// cbx_pkg
// Shared types and constants for the cubic Bezier x-to-parameter unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbx_pkg;

  localparam int COORD_W     = 32;
  localparam int PARAM_OUT_W = 17;
  localparam int MAXIT_W     = 10;
  localparam int TOL_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MAXIT_W-1:0] MAXIT_RESET = 10'd32;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OUT_BEFORE    = 2'd0,
    OUT_PAST      = 2'd1,
    OUT_CONVERGED = 2'd2,
    OUT_LIMIT     = 2'd3
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     split;
    logic     update;
    logic     emit;
    outcome_t outcome;
  } cbx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_start;
    logic past;
    logic conv;
  } cbx_status_t;

endpackage

[rtl/cbx_ctrl.sv]
// ----------------------------------------------------------------------------
// cbx_ctrl
// Sequencer for the bisection search: end checks, split/decide steps,
// iteration count and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbx_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cbx_pkg::MAXIT_W-1:0]   max_iterations,
  input  cbx_pkg::cbx_status_t          status,
  output cbx_pkg::cbx_cmd_t             cmd
);
  import cbx_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ENDS   = 5'b00010,
    ST_SPLIT  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_LIMIT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAXIT_W-1:0]   iter_r, iter_nxt;
  logic [MAXIT_W-1:0]   iter_inc;

  assign iter_inc = iter_r + 1'b1;
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    iter_nxt    = iter_r;
    cmd         = '0;
    cmd.outcome = OUT_BEFORE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = ST_ENDS;
        end
      end
      ST_ENDS: begin
        // start check wins over end check
        if (status.at_start) begin
          cmd.emit    = 1'b1;
          cmd.outcome = OUT_BEFORE;
          state_nxt   = ST_IDLE;
        end else if (status.past) begin
          cmd.emit    = 1'b1;
          cmd.outcome = OUT_PAST;
          state_nxt   = ST_IDLE;
        end else if (max_iterations == '0) begin
          state_nxt = ST_LIMIT;
        end else begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.conv) begin
          cmd.emit    = 1'b1;
          cmd.outcome = OUT_CONVERGED;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          iter_nxt   = iter_inc;
          state_nxt  = (iter_inc == max_iterations) ? ST_LIMIT : ST_SPLIT;
        end
      end
      ST_LIMIT: begin
        cmd.emit    = 1'b1;
        cmd.outcome = OUT_LIMIT;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

`ifndef SYNTH
  a_start_to_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_ENDS))
    else $error("accepted beat did not enter end check");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == ST_IDLE))
    else $error("controller not idle after emitting a result");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");
`endif

endmodule

[rtl/cbx_datapath.sv]
// ----------------------------------------------------------------------------
// cbx_datapath
// Control points, de Casteljau halving, parameter interval and result
// register. Each bisection step runs the halving, then the decide/update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbx_datapath #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbx_pkg::cbx_cmd_t                 cmd,
  input  logic [cbx_pkg::TOL_W-1:0]         tolerance,
  input  cbx_pkg::coord_t                   in_target_x,
  input  cbx_pkg::coord_t                   in_start_x,
  input  cbx_pkg::coord_t                   in_end_x,
  input  cbx_pkg::coord_t                   in_ctrl_first_x,
  input  cbx_pkg::coord_t                   in_ctrl_second_x,
  output cbx_pkg::cbx_status_t              status,
  output logic                              out_strobe,
  output logic [cbx_pkg::PARAM_OUT_W-1:0]   out_curve_param,
  output logic [1:0]                        out_outcome
);
  import cbx_pkg::*;

  localparam int PW = PARAM_FRAC_BITS + 1;
  localparam logic [PW-1:0] ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  function automatic coord_t mid_pt(input coord_t p, input coord_t q);
    logic signed [COORD_W:0] s;
    s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    return s[COORD_W:1];
  endfunction

  coord_t tx_r, p0_r, p1_r, p2_r, p3_r;
  coord_t a_r, c_r, d_r, e_r;
  coord_t a_w, b_w, c_w, d_w, e_w, f_w;
  logic [PW-1:0] u_r, v_r, mid_par;
  logic [PW:0]   par_sum;

  logic signed [COORD_W:0]   de_sum;
  logic signed [COORD_W+1:0] err2;   // d + e - 2*tx
  logic signed [COORD_W:0]   diff;   // f - tx
  logic signed [COORD_W:0]   tol_s;
  logic                      f_below;

  logic                   out_strobe_r;
  logic [PARAM_OUT_W-1:0] out_curve_param_r;
  outcome_t               out_outcome_r;

  // halving tree, registered in the split state of a step
  assign a_w = mid_pt(p0_r, p1_r);
  assign b_w = mid_pt(p1_r, p2_r);
  assign c_w = mid_pt(p2_r, p3_r);
  assign d_w = mid_pt(a_w, b_w);
  assign e_w = mid_pt(b_w, c_w);

  // decide state: f and its distance to the target
  assign de_sum  = {d_r[COORD_W-1], d_r} + {e_r[COORD_W-1], e_r};
  assign f_w     = de_sum[COORD_W:1];
  assign err2    = {{2{d_r[COORD_W-1]}}, d_r} + {{2{e_r[COORD_W-1]}}, e_r}
                 - {tx_r[COORD_W-1], tx_r, 1'b0};
  // floor((d+e)/2) - tx == floor((d+e-2tx)/2)
  assign diff    = err2[COORD_W+1:1];
  assign tol_s   = {{(COORD_W+1-TOL_W){1'b0}}, tolerance};
  assign f_below = diff[COORD_W];

  assign status.at_start = (tx_r <= p0_r);
  assign status.past     = (tx_r >= p3_r);
  assign status.conv     = (diff < tol_s) && (diff > -tol_s);

  assign par_sum = {1'b0, u_r} + {1'b0, v_r};
  assign mid_par = par_sum[PW:1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx_r <= in_target_x;
      p0_r <= in_start_x;
      p1_r <= in_ctrl_first_x;
      p2_r <= in_ctrl_second_x;
      p3_r <= in_end_x;
    end else if (cmd.update) begin
      if (f_below) begin
        p0_r <= f_w;
        p1_r <= e_r;
        p2_r <= c_r;
      end else begin
        p1_r <= a_r;
        p2_r <= d_r;
        p3_r <= f_w;
      end
    end
    if (cmd.split) begin
      a_r <= a_w;
      c_r <= c_w;
      d_r <= d_w;
      e_r <= e_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= '0;
      v_r <= ONE;
    end else if (cmd.load) begin
      u_r <= '0;
      v_r <= ONE;
    end else if (cmd.update) begin
      if (f_below) begin
        u_r <= mid_par;
      end else begin
        v_r <= mid_par;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_outcome_r <= cmd.outcome;
      case (cmd.outcome)
        OUT_BEFORE: out_curve_param_r <= '0;
        OUT_PAST:   out_curve_param_r <= PARAM_OUT_W'(ONE);
        default:    out_curve_param_r <= PARAM_OUT_W'(mid_par);
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_curve_param = out_curve_param_r;
  assign out_outcome     = out_outcome_r;

`ifndef SYNTH
  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    u_r <= v_r)
    else $error("parameter interval inverted");

  a_interval_unit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r <= ONE)
    else $error("parameter interval beyond 1.0");

  a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_outcome_r == OUT_BEFORE) |-> (out_curve_param_r == '0))
    else $error("before-start beat with nonzero parameter");
`endif

endmodule

[rtl/cubic_bezier_x_to_parameter_unit.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_x_to_parameter_unit
// Finds the parameter at which a 1-D cubic Bezier reaches a target x.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the five Q15.16 coordinates on in_* and pulse start while busy is
//   low; the beat is taken at that edge. One item is worked at a time.
//   The result (curve_param in Q1.16, outcome code) shows on out_* for one
//   cycle with out_strobe high; the receiver cannot stall it, so it must
//   capture the beat in that cycle. A new item may start while it shows.
//   busy stays high through the end checks, each bisection step (halving
//   tree, then decide/update) and, on the iteration limit, the emit state;
//   out_strobe is high in the first cycle busy is low.
//   A target at/below start or at/above end is emitted from the end checks.
//   Configuration: cfg_index 0 = max_iterations, 1 = tolerance; write only
//   while busy is low. cfg_ready is always high.
//   Reset restores max_iterations 32, tolerance 1 and drops any item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bezier_x_to_parameter_unit #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  cbx_pkg::coord_t                    in_target_x,
  input  cbx_pkg::coord_t                    in_start_x,
  input  cbx_pkg::coord_t                    in_end_x,
  input  cbx_pkg::coord_t                    in_ctrl_first_x,
  input  cbx_pkg::coord_t                    in_ctrl_second_x,
  output logic                               out_strobe,
  output logic [cbx_pkg::PARAM_OUT_W-1:0]    out_curve_param,
  output logic [1:0]                         out_outcome,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbx_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbx_pkg::*;

  logic [MAXIT_W-1:0] max_iter_r;
  logic [TOL_W-1:0]   tol_r;
  cbx_cmd_t           cmd;
  cbx_status_t        status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAXIT_RESET;
      tol_r      <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_ITER) begin
        max_iter_r <= cfg_data[MAXIT_W-1:0];
      end else if (cfg_index == REG_TOLERANCE) begin
        tol_r <= cfg_data[TOL_W-1:0];
      end
    end
  end

  cbx_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .max_iterations (max_iter_r),
    .status         (status),
    .cmd            (cmd)
  );

  cbx_datapath #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .tolerance        (tol_r),
    .in_target_x      (in_target_x),
    .in_start_x       (in_start_x),
    .in_end_x         (in_end_x),
    .in_ctrl_first_x  (in_ctrl_first_x),
    .in_ctrl_second_x (in_ctrl_second_x),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_curve_param  (out_curve_param),
    .out_outcome      (out_outcome)
  );

endmodule
